// ===== rtl/bxs_pkg.sv =====
package bxs_pkg;

    localparam logic [63:0] BOOT_SEED    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] MUL_LO       = 32'h4F6C_DD1D;
    localparam logic [31:0] MUL_HI       = 32'h2545_F491;
    localparam int          SHIFT_A      = 12;
    localparam int          SHIFT_B      = 25;
    localparam int          SHIFT_C      = 27;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

    // remainder unit retires two dividend bits per cycle
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_MIX,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_CHECK,
        ST_MOD,
        ST_EMIT
    } bxs_state_t;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_HL,
        MUL_LH
    } bxs_mul_t;

    typedef struct packed {
        logic     load;
        logic     div_start_lim;
        logic     div_start_word;
        logic     div_step;
        logic     draw;
        logic     lim_load;
        logic     mul_en;
        bxs_mul_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     out_load;
    } bxs_cmd_t;

    typedef struct packed {
        logic in_err;
        logic div_last;
        logic word_ge_lim;
        logic out_free;
    } bxs_status_t;

endpackage

// ===== rtl/bxs_ctrl.sv =====
module bxs_ctrl
    import bxs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  bxs_status_t status,
    output bxs_cmd_t    cmd
);

    bxs_state_t state_reg;
    bxs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_LL;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load          = 1'b1;
                    cmd.div_start_lim = 1'b1;
                    state_next        = status.in_err ? ST_EMIT : ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                cmd.lim_load = 1'b1;
                cmd.draw     = 1'b1;
                state_next   = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LL;
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_HL;
                cmd.acc_load = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LH;
                cmd.acc_add = 1'b1;
                state_next  = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                // rejection: redraw until the word falls below the limit
                if (status.word_ge_lim)
                begin
                    state_next = ST_MIX;
                end
                else
                begin
                    cmd.div_start_word = 1'b1;
                    state_next         = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bxs_dpath.sv =====
module bxs_dpath
    import bxs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic               seed_wr_en,
    input  logic        [63:0] seed_value,
    input  logic               out_stall,
    input  bxs_cmd_t           cmd,
    output bxs_status_t        status,
    output logic               out_valid,
    output logic signed [31:0] value,
    output logic               range_error
);

    logic [63:0]      gen_state_reg;
    logic [63:0]      gen_state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;

    logic [31:0] lower_reg;
    logic [32:0] span_reg;
    logic        err_reg;
    logic [63:0] limit_reg;
    logic [63:0] dvd_reg;
    logic [32:0] rem_reg;
    logic [63:0] word_reg;
    logic [63:0] prod_reg;
    logic [31:0] value_reg;
    logic        range_error_reg;

    logic [31:0] lo_b;
    logic [31:0] hi_b;
    logic [32:0] span_in;
    logic [63:0] x1;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [32:0] rem_1;
    logic [32:0] rem_2;

    // one restoring remainder step: shift in a bit, subtract span if it fits
    function automatic logic [32:0] rem_step(input logic [32:0] r, input logic b,
                                             input logic [32:0] d);
        logic [33:0] s;
        logic [33:0] diff;
        s    = {r, b};
        diff = s - {1'b0, d};
        if (s >= {1'b0, d})
        begin
            return diff[32:0];
        end
        return s[32:0];
    endfunction

    // bias by the sign bit so unsigned compare acts as signed
    assign lo_b    = lower_bound ^ SIGN_BIT;
    assign hi_b    = upper_bound ^ SIGN_BIT;
    assign span_in = {1'b0, hi_b} - {1'b0, lo_b} + 33'd1;

    assign x1 = gen_state_reg ^ (gen_state_reg >> SHIFT_A);
    assign x2 = x1 ^ (x1 << SHIFT_B);
    assign x3 = x2 ^ (x2 >> SHIFT_C);

    assign mul_a = (cmd.mul_sel == MUL_HL) ? gen_state_reg[63:32] : gen_state_reg[31:0];
    assign mul_b = (cmd.mul_sel == MUL_LH) ? MUL_HI : MUL_LO;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    assign rem_1 = rem_step(rem_reg, dvd_reg[63], span_reg);
    assign rem_2 = rem_step(rem_1, dvd_reg[62], span_reg);

    always_comb
    begin
        gen_state_next = gen_state_reg;
        if (seed_wr_en)
        begin
            gen_state_next = (seed_value == 64'd0) ? BOOT_SEED : seed_value;
        end
        else if (cmd.draw)
        begin
            gen_state_next = x3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= BOOT_SEED;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
            if (cmd.div_start_lim || cmd.div_start_word)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lower_reg <= lower_bound;
            span_reg  <= span_in;
            err_reg   <= (lo_b > hi_b);
        end
        if (cmd.div_start_lim)
        begin
            dvd_reg <= '1;
            rem_reg <= '0;
        end
        else if (cmd.div_start_word)
        begin
            dvd_reg <= word_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[61:0], 2'b00};
            rem_reg <= rem_2;
        end
        // all-ones minus the remainder is its complement
        if (cmd.lim_load)
        begin
            limit_reg <= ~{31'd0, rem_reg};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.acc_load)
        begin
            word_reg <= prod_reg;
        end
        else if (cmd.acc_add)
        begin
            word_reg[63:32] <= word_reg[63:32] + prod_reg[31:0];
        end
        if (cmd.out_load)
        begin
            value_reg       <= err_reg ? 32'd0 : lower_reg + rem_reg[31:0];
            range_error_reg <= err_reg;
        end
    end

    assign status.in_err      = (lo_b > hi_b);
    assign status.div_last    = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign status.word_ge_lim = (word_reg >= limit_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign range_error = range_error_reg;

endmodule

// ===== rtl/bounded_xorshift64star_rng_top.sv =====
// Bounded uniform integer generator on a 64-bit xorshift64* engine. Each request
// carries a signed inclusive range; the result is lower_bound + (word mod span),
// with draws below the largest multiple of span so the result is unbiased. An
// inverted range returns 0 with range_error set and leaves the engine untouched.
// A good range runs two remainder passes (limit, then word mod span) through a
// 2-bit-per-cycle restoring unit, and each draw (almost always just one) uses
// one 32x32 multiplier three times. One request is in flight at a
// time; a new one is taken while the previous result still waits in the output
// register. Writing seed_value reloads the engine at once (zero selects the default
// seed).
module bounded_xorshift64star_rng_top
    import bxs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic               range_error,
    input  logic               seed_wr_en,
    input  logic        [63:0] seed_value
);

    bxs_cmd_t    cmd;
    bxs_status_t status;

    bxs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bxs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .seed_wr_en  (seed_wr_en),
        .seed_value  (seed_value),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .value       (value),
        .range_error (range_error)
    );

    // an accepted transaction holds off the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while one is in flight");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> value == 32'sd0)
        else $error("range error result carries a nonzero value");

    // result is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten before it was taken");

endmodule
